[hdl/rxtl_pkg.sv]
// ----------------------------------------------------------------------------
// rxtl_pkg: shared types and constants of the regex thread list
// Entry layout, operation and status codes, and the structs that pass
// between the list cells and the control logic.
// ----------------------------------------------------------------------------
`default_nettype none

package rxtl_pkg;

	localparam int LIST_DEPTH  = 32;
	localparam int SUB_SLOTS   = 4;
	localparam int FIELD_SLOTS = 4;
	localparam int POS_W       = 16;
	localparam int INST_W      = 10;
	localparam int EIDX_W      = 5;
	localparam int CFG_W       = 3;
	localparam int IDX_W       = $clog2(LIST_DEPTH);
	localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
	localparam int IDX_CMP_W   = (IDX_W > EIDX_W) ? IDX_W : EIDX_W;

	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [INST_W-1:0]    inst_t;
	typedef logic [EIDX_W-1:0]    eidx_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [IDX_CMP_W-1:0] idx_cmp_t;
	typedef logic [CFG_W-1:0]     cfg_t;
	typedef logic [FIELD_SLOTS-1:0][POS_W-1:0] field_pos_t;

	typedef enum logic [1:0] {
		OP_CLEAR     = 2'd0,
		OP_ADD       = 2'd1,
		OP_ADD_EMPTY = 2'd2,
		OP_READ      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_APPENDED = 3'd0,
		ST_REPLACED = 3'd1,
		ST_KEPT     = 3'd2,
		ST_FULL     = 3'd3,
		ST_READ     = 3'd4,
		ST_CLEARED  = 3'd5
	} status_t;

	typedef struct packed {
		inst_t                          inst;
		logic [SUB_SLOTS-1:0][POS_W-1:0] starts;
		logic [SUB_SLOTS-1:0][POS_W-1:0] ends;
	} entry_t;

	// broadcast to every cell while an item is in flight
	typedef struct packed {
		logic  add;
		logic  rd;
		inst_t inst;
		eidx_t read_index;
		cnt_t  count;
	} query_t;

	typedef struct packed {
		logic   en;
		idx_t   index;
		entry_t data;
	} wr_t;

	// each cell drives zero unless selected, so answers combine by OR
	typedef struct packed {
		logic   hit;
		idx_t   index;
		entry_t data;
	} cell_rsp_t;

	function automatic pos_t get_start(entry_t e, int s);
		pos_t v;
		v = '0;
		if (s < SUB_SLOTS) begin
			v = e.starts[s];
		end
		return v;
	endfunction

	function automatic pos_t get_end(entry_t e, int s);
		pos_t v;
		v = '0;
		if (s < SUB_SLOTS) begin
			v = e.ends[s];
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[hdl/rxtl_in_if.sv]
// ----------------------------------------------------------------------------
// rxtl_in_if: request channel of the regex thread list
// Valid/ready channel carrying one list operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface rxtl_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 op;
	logic [rxtl_pkg::INST_W-1:0] inst_id;
	logic [rxtl_pkg::EIDX_W-1:0] read_index;
	logic [rxtl_pkg::POS_W-1:0]  start_0;
	logic [rxtl_pkg::POS_W-1:0]  end_0;
	logic [rxtl_pkg::POS_W-1:0]  start_1;
	logic [rxtl_pkg::POS_W-1:0]  end_1;
	logic [rxtl_pkg::POS_W-1:0]  start_2;
	logic [rxtl_pkg::POS_W-1:0]  end_2;
	logic [rxtl_pkg::POS_W-1:0]  start_3;
	logic [rxtl_pkg::POS_W-1:0]  end_3;

	modport source (
		output valid, op, inst_id, read_index,
		       start_0, end_0, start_1, end_1, start_2, end_2, start_3, end_3,
		input  ready
	);
	modport sink (
		input  valid, op, inst_id, read_index,
		       start_0, end_0, start_1, end_1, start_2, end_2, start_3, end_3,
		output ready
	);
endinterface

`default_nettype wire

[hdl/rxtl_out_if.sv]
// ----------------------------------------------------------------------------
// rxtl_out_if: result channel of the regex thread list
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rxtl_out_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic [rxtl_pkg::EIDX_W-1:0] entry_index;
	logic [rxtl_pkg::INST_W-1:0] entry_inst;
	logic [rxtl_pkg::POS_W-1:0]  out_start_0;
	logic [rxtl_pkg::POS_W-1:0]  out_end_0;
	logic [rxtl_pkg::POS_W-1:0]  out_start_1;
	logic [rxtl_pkg::POS_W-1:0]  out_end_1;
	logic [rxtl_pkg::POS_W-1:0]  out_start_2;
	logic [rxtl_pkg::POS_W-1:0]  out_end_2;
	logic [rxtl_pkg::POS_W-1:0]  out_start_3;
	logic [rxtl_pkg::POS_W-1:0]  out_end_3;

	modport source (
		output valid, status, entry_index, entry_inst,
		       out_start_0, out_end_0, out_start_1, out_end_1,
		       out_start_2, out_end_2, out_start_3, out_end_3,
		input  ready
	);
	modport sink (
		input  valid, status, entry_index, entry_inst,
		       out_start_0, out_end_0, out_start_1, out_end_1,
		       out_start_2, out_end_2, out_start_3, out_end_3,
		output ready
	);
endinterface

`default_nettype wire

[hdl/rxtl_cell.sv]
// ----------------------------------------------------------------------------
// rxtl_cell: one thread list entry
// Holds one thread, compares it against the query and drives its contents
// when selected; zero otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module rxtl_cell (
	input  wire logic               clk,
	input  wire rxtl_pkg::idx_t     cell_index,
	input  wire rxtl_pkg::query_t   query,
	input  wire rxtl_pkg::wr_t      wr,
	output rxtl_pkg::cell_rsp_t     rsp
);

	rxtl_pkg::entry_t entry_q;
	logic             live;
	logic             hit;
	logic             rd_hit;

	// entries below the count are live, the rest hold stale data
	assign live   = rxtl_pkg::cnt_t'(cell_index) < query.count;
	assign hit    = query.add && live && (entry_q.inst == query.inst);
	assign rd_hit = query.rd && live &&
	                (rxtl_pkg::idx_cmp_t'(query.read_index) ==
	                 rxtl_pkg::idx_cmp_t'(cell_index));

	assign rsp.hit   = hit;
	assign rsp.index = hit ? cell_index : '0;
	assign rsp.data  = (hit || rd_hit) ? entry_q : '0;

	always_ff @(posedge clk) begin
		if (wr.en && (wr.index == cell_index)) begin
			entry_q <= wr.data;
		end
	end

endmodule

`default_nettype wire

[hdl/regex_thread_list_insert_core.sv]
// ----------------------------------------------------------------------------
// regex_thread_list_insert_core: thread list of a Pike-style regex NFA
// Clear, add thread, add empty thread and read entry over a row of list
// cells searched in parallel.
// ----------------------------------------------------------------------------
// A request transfer lands in an input register; while it is held there every
// cell compares its instruction id in parallel and the selected cell drives
// its contents onto an OR bus. When the output register is free or being
// drained, a new or replacing entry is written back and the result goes to
// the output register, from which it transfers. One request per cycle is
// sustained while the result side keeps up: the input register refills in
// the same cycle that it hands its item to the output register. The list
// itself needs no clearing pass: live entries are those below the thread
// count, which reset and the clear operation zero.
// ----------------------------------------------------------------------------
`default_nettype none

module regex_thread_list_insert_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_wdata,
	rxtl_in_if.sink                 req,
	rxtl_out_if.source              rsp
);

	// configuration
	rxtl_pkg::cfg_t subs_q;

	// input stage
	logic                   valid_s1;
	rxtl_pkg::op_t          op_s1;
	rxtl_pkg::inst_t        inst_s1;
	rxtl_pkg::eidx_t        read_index_s1;
	rxtl_pkg::field_pos_t   start_s1;
	rxtl_pkg::field_pos_t   end_s1;

	// list state
	rxtl_pkg::cnt_t         count_q;

	// output register
	logic                   res_valid_q;
	rxtl_pkg::status_t      res_status_q;
	rxtl_pkg::eidx_t        res_index_q;
	rxtl_pkg::entry_t       res_data_q;

	// cell row
	rxtl_pkg::query_t                         query;
	rxtl_pkg::wr_t                            wr;
	rxtl_pkg::cell_rsp_t [rxtl_pkg::LIST_DEPTH-1:0] cell_rsp;
	logic [rxtl_pkg::LIST_DEPTH-1:0]          hit_vec;

	logic                   proc;
	logic                   is_add;
	logic                   any_hit;
	logic                   full;
	logic                   newer;
	rxtl_pkg::idx_t         acc_index;
	rxtl_pkg::entry_t       acc_data;
	rxtl_pkg::entry_t       new_data;
	rxtl_pkg::cfg_t         n_slots;
	rxtl_pkg::status_t      status_d;
	rxtl_pkg::eidx_t        index_d;
	rxtl_pkg::entry_t       data_d;

	// advance when the output register is free or being drained
	assign proc      = valid_s1 && (!res_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || proc;

	assign is_add = (op_s1 == rxtl_pkg::OP_ADD) || (op_s1 == rxtl_pkg::OP_ADD_EMPTY);
	assign full   = count_q == rxtl_pkg::cnt_t'(rxtl_pkg::LIST_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subs_q <= rxtl_pkg::cfg_t'(1);
		end else if (cfg_we) begin
			subs_q <= cfg_wdata;
		end
	end

	// capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1         <= rxtl_pkg::op_t'(req.op);
			inst_s1       <= req.inst_id;
			read_index_s1 <= req.read_index;
			start_s1      <= {req.start_3, req.start_2, req.start_1, req.start_0};
			end_s1        <= {req.end_3, req.end_2, req.end_1, req.end_0};
		end
	end

	// broadcast the query to the cells
	assign query.add        = valid_s1 && is_add;
	assign query.rd         = valid_s1 && (op_s1 == rxtl_pkg::OP_READ);
	assign query.inst       = inst_s1;
	assign query.read_index = read_index_s1;
	assign query.count      = count_q;

	for (genvar i = 0; i < rxtl_pkg::LIST_DEPTH; i++) begin : g_cell
		rxtl_cell u_cell (
			.clk        (clk),
			.cell_index (rxtl_pkg::idx_t'(i)),
			.query      (query),
			.wr         (wr),
			.rsp        (cell_rsp[i])
		);
		assign hit_vec[i] = cell_rsp[i].hit;
	end

	// live ids are unique, so at most one cell answers and OR picks it
	always_comb begin
		acc_index = '0;
		acc_data  = '0;
		for (int i = 0; i < rxtl_pkg::LIST_DEPTH; i++) begin
			acc_index = acc_index | cell_rsp[i].index;
			acc_data  = acc_data | cell_rsp[i].data;
		end
	end
	assign any_hit = |hit_vec;

	// slot 0 is always copied; clamp to the implemented slot count
	always_comb begin
		if (subs_q == '0) begin
			n_slots = rxtl_pkg::cfg_t'(1);
		end else if (subs_q > rxtl_pkg::cfg_t'(rxtl_pkg::SUB_SLOTS)) begin
			n_slots = rxtl_pkg::cfg_t'(rxtl_pkg::SUB_SLOTS);
		end else begin
			n_slots = subs_q;
		end
	end

	// build the entry to write; an empty thread keeps only the slot 0 start
	always_comb begin
		new_data      = '0;
		new_data.inst = inst_s1;
		for (int s = 0; s < rxtl_pkg::SUB_SLOTS; s++) begin
			if (rxtl_pkg::cfg_t'(s) < n_slots) begin
				if ((op_s1 == rxtl_pkg::OP_ADD) || (s == 0)) begin
					new_data.starts[s] = start_s1[s];
				end
				if (op_s1 == rxtl_pkg::OP_ADD) begin
					new_data.ends[s] = end_s1[s];
				end
			end
		end
	end

	assign newer = start_s1[0] < acc_data.starts[0];

	// decide the result and the write-back
	always_comb begin
		status_d = rxtl_pkg::ST_CLEARED;
		index_d  = '0;
		data_d   = '0;
		wr.en    = 1'b0;
		wr.index = count_q[rxtl_pkg::IDX_W-1:0];
		wr.data  = new_data;
		unique case (op_s1) inside
			rxtl_pkg::OP_CLEAR: begin
				status_d = rxtl_pkg::ST_CLEARED;
			end
			rxtl_pkg::OP_READ: begin
				status_d = rxtl_pkg::ST_READ;
				index_d  = read_index_s1;
				data_d   = acc_data;
			end
			rxtl_pkg::OP_ADD, rxtl_pkg::OP_ADD_EMPTY: begin
				if (any_hit) begin
					index_d  = rxtl_pkg::eidx_t'(acc_index);
					wr.index = acc_index;
					if (newer) begin
						status_d = rxtl_pkg::ST_REPLACED;
						data_d   = new_data;
						wr.en    = proc;
					end else begin
						status_d = rxtl_pkg::ST_KEPT;
						data_d   = acc_data;
					end
				end else if (full) begin
					status_d = rxtl_pkg::ST_FULL;
				end else begin
					status_d = rxtl_pkg::ST_APPENDED;
					index_d  = rxtl_pkg::eidx_t'(count_q);
					data_d   = new_data;
					wr.en    = proc;
				end
			end
			default: begin
				status_d = rxtl_pkg::ST_CLEARED;
			end
		endcase
	end

	// thread count: zero on clear, advance on append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (proc) begin
			if (op_s1 == rxtl_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (is_add && !any_hit && !full) begin
				count_q <= count_q + rxtl_pkg::cnt_t'(1);
			end
		end
	end

	// output register: hold until the result transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_status_q <= status_d;
			res_index_q  <= index_d;
			res_data_q   <= data_d;
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.status      = res_status_q;
	assign rsp.entry_index = res_index_q;
	assign rsp.entry_inst  = res_data_q.inst;
	assign rsp.out_start_0 = rxtl_pkg::get_start(res_data_q, 0);
	assign rsp.out_end_0   = rxtl_pkg::get_end(res_data_q, 0);
	assign rsp.out_start_1 = rxtl_pkg::get_start(res_data_q, 1);
	assign rsp.out_end_1   = rxtl_pkg::get_end(res_data_q, 1);
	assign rsp.out_start_2 = rxtl_pkg::get_start(res_data_q, 2);
	assign rsp.out_end_2   = rxtl_pkg::get_end(res_data_q, 2);
	assign rsp.out_start_3 = rxtl_pkg::get_start(res_data_q, 3);
	assign rsp.out_end_3   = rxtl_pkg::get_end(res_data_q, 3);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rxtl_pkg::cnt_t'(rxtl_pkg::LIST_DEPTH))
		else $error("thread count above list depth");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("instruction id found in more than one live entry");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && (op_s1 == rxtl_pkg::OP_CLEAR)) |=> (count_q == '0))
		else $error("list not empty after clear");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && (status_d == rxtl_pkg::ST_APPENDED)) |=>
		(count_q == $past(count_q) + rxtl_pkg::cnt_t'(1)))
		else $error("append did not advance the thread count");
`endif

endmodule

`default_nettype wire

[tb/regex_thread_list_insert_core_tb.sv]
// ----------------------------------------------------------------------------
// regex_thread_list_insert_core_tb: self-checking bench of the thread list
// Drives clear, add, add-empty and read requests through the valid/ready
// channels with random gaps and stalls on both sides. A scoreboard holds its
// own copy of the list, predicts every result in order and compares each
// result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module regex_thread_list_insert_core_tb;

	import rxtl_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE       = 6;    // margin after draining before the next step
	localparam int PHASE_ITEMS  = 180;
	localparam int LONG_HOLD    = 400;  // receiver hold-off in cycles
	localparam int POOL_SPAN    = 40;   // ids per phase pool, a bit over the list depth
	localparam int MAX_SHOWN    = 10;

	localparam int HOLD_PHASE  = 2;
	localparam int QUIET_PHASE = 4;
	localparam int PAUSE_PHASE = 5;

	typedef struct packed {
		op_t        op;
		inst_t      inst;
		eidx_t      read_index;
		field_pos_t starts;
		field_pos_t ends;
	} list_request_t;

	typedef struct packed {
		logic [2:0] status;
		eidx_t      index;
		inst_t      inst;
		field_pos_t starts;
		field_pos_t ends;
	} list_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: a private copy of the thread list plus the queue of results
	// still owed by the block.
	// ------------------------------------------------------------------------
	class thread_list_board;
		cfg_t         slots_reg;
		int           live_count;
		inst_t        inst_q[LIST_DEPTH];
		field_pos_t   starts_q[LIST_DEPTH];
		field_pos_t   ends_q[LIST_DEPTH];
		list_result_t pending_results[$];
		int           mismatches;

		function new();
			slots_reg  = 3'd1;
			live_count = 0;
			mismatches = 0;
		endfunction

		// slot 0 is always copied; values past the slot count saturate
		function int active_slots();
			if (slots_reg == 0) begin
				return 1;
			end
			if (slots_reg > SUB_SLOTS) begin
				return SUB_SLOTS;
			end
			return int'(slots_reg);
		endfunction

		function void store_entry(int e, list_request_t rq);
			int  n;
			bit  empty;
			n     = active_slots();
			empty = (rq.op == OP_ADD_EMPTY);
			for (int s = 0; s < FIELD_SLOTS; s++) begin
				starts_q[e][s] = '0;
				ends_q[e][s]   = '0;
				if (s < n && (!empty || s == 0)) begin
					starts_q[e][s] = rq.starts[s];
					ends_q[e][s]   = empty ? '0 : rq.ends[s];
				end
			end
		endfunction

		function list_result_t entry_result(status_t st, int idx, bit live);
			list_result_t r;
			r        = '0;
			r.status = st;
			r.index  = eidx_t'(idx);
			if (live) begin
				r.inst   = inst_q[idx];
				r.starts = starts_q[idx];
				r.ends   = ends_q[idx];
			end
			return r;
		endfunction

		function list_result_t predict_request(list_request_t rq);
			case (rq.op)
				OP_CLEAR: begin
					live_count = 0;
					return entry_result(ST_CLEARED, 0, 1'b0);
				end
				OP_READ: begin
					return entry_result(ST_READ, rq.read_index, rq.read_index < live_count);
				end
				default: begin
					// search the live entries first; a hit never appends
					for (int i = 0; i < live_count; i++) begin
						if (inst_q[i] == rq.inst) begin
							if (rq.starts[0] < starts_q[i][0]) begin
								store_entry(i, rq);
								return entry_result(ST_REPLACED, i, 1'b1);
							end
							return entry_result(ST_KEPT, i, 1'b1);
						end
					end
					if (live_count >= LIST_DEPTH) begin
						return entry_result(ST_FULL, 0, 1'b0);
					end
					inst_q[live_count] = rq.inst;
					store_entry(live_count, rq);
					live_count++;
					return entry_result(ST_APPENDED, live_count - 1, 1'b1);
				end
			endcase
		endfunction

		function void note_request(list_request_t rq);
			pending_results.push_back(predict_request(rq));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("mismatch on %s: expected %h, got %h", name, want, got);
				end
			end
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("result with nothing expected: status %h index %h inst %h",
					         got.status, got.index, got.inst);
				end
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("entry_index", want.index, got.index);
			compare_field("entry_inst", want.inst, got.inst);
			for (int s = 0; s < FIELD_SLOTS; s++) begin
				compare_field($sformatf("out_start_%0d", s), want.starts[s], got.starts[s]);
				compare_field($sformatf("out_end_%0d", s), want.ends[s], got.ends[s]);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;

	rxtl_in_if  req_ch ();
	rxtl_out_if rsp_ch ();

	thread_list_board board;

	bit hold_request;   // ask the receiver for one long hold-off
	bit no_idle;        // suppress gaps and stalls on both sides
	int cycle_count;

	always #5 clk = ~clk;

	regex_thread_list_insert_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// ------------------------------------------------------------------------
	// Monitor: sample both channels at the rising edge. Check the result
	// before noting the request; a request's own result passes the input and
	// output registers first, so the queue front is always older.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : sample_transfers
		list_request_t seen;
		list_result_t  got;
		if (arst_n === 1'b1) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.status = rsp_ch.status;
				got.index  = rsp_ch.entry_index;
				got.inst   = rsp_ch.entry_inst;
				got.starts = {rsp_ch.out_start_3, rsp_ch.out_start_2,
				              rsp_ch.out_start_1, rsp_ch.out_start_0};
				got.ends   = {rsp_ch.out_end_3, rsp_ch.out_end_2,
				              rsp_ch.out_end_1, rsp_ch.out_end_0};
				board.check_result(got);
			end
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
				seen.op         = op_t'(req_ch.op);
				seen.inst       = req_ch.inst_id;
				seen.read_index = req_ch.read_index;
				seen.starts     = {req_ch.start_3, req_ch.start_2, req_ch.start_1, req_ch.start_0};
				seen.ends       = {req_ch.end_3, req_ch.end_2, req_ch.end_1, req_ch.end_0};
				board.note_request(seen);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: one ready level per run of cycles, changed at the falling
	// edge. Mostly short runs, now and then a long stall, and on request a
	// long hold-off so the block backs up into its request channel.
	// ------------------------------------------------------------------------
	initial begin : drive_ready
		logic level;
		int   run;
		int   pick;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (hold_request) begin
				hold_request = 1'b0;
				level        = 1'b0;
				run          = LONG_HOLD;
			end else if (no_idle) begin
				level = 1'b1;
				run   = 1;
			end else if (pick < 55) begin
				level = 1'b1;
				run   = $urandom_range(1, 24);
			end else if (pick < 90) begin
				level = 1'b0;
				run   = $urandom_range(1, 3);
			end else begin
				level = 1'b0;
				run   = $urandom_range(8, 40);
			end
			rsp_ch.ready <= level;
			repeat (run) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if it drags far past the slowest legal schedule.
	// ------------------------------------------------------------------------
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[regex_thread_list_insert_core] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sender tasks. Every task starts and ends at a falling edge.
	// ------------------------------------------------------------------------

	// hold valid until the transfer; leave valid high for a back-to-back item
	task automatic send_request(list_request_t rq);
		req_ch.valid      <= 1'b1;
		req_ch.op         <= rq.op;
		req_ch.inst_id    <= rq.inst;
		req_ch.read_index <= rq.read_index;
		req_ch.start_0    <= rq.starts[0];
		req_ch.end_0      <= rq.ends[0];
		req_ch.start_1    <= rq.starts[1];
		req_ch.end_1      <= rq.ends[1];
		req_ch.start_2    <= rq.starts[2];
		req_ch.end_2      <= rq.ends[2];
		req_ch.start_3    <= rq.starts[3];
		req_ch.end_3      <= rq.ends[3];
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	function automatic int sender_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (no_idle || pick < 60) begin
			return 0;
		end
		if (pick < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic offer(list_request_t rq);
		int gap;
		gap = sender_gap();
		send_request(rq);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// drop valid and wait until every owed result has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (board.pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// only called with the block idle
	task automatic write_slots(cfg_t value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		board.slots_reg = value;
	endtask

	// ------------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------------

	// mostly small positions so that start compares tie and cross often
	function automatic pos_t random_pos();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			return pos_t'($urandom_range(0, 15));
		end
		if (pick < 50) begin
			return ($urandom_range(0, 1) == 1) ? '1 : '0;
		end
		return pos_t'($urandom);
	endfunction

	function automatic list_request_t thread_req(op_t op, inst_t id, pos_t first_start);
		list_request_t rq;
		rq.op         = op;
		rq.inst       = id;
		rq.read_index = eidx_t'($urandom);
		for (int s = 0; s < FIELD_SLOTS; s++) begin
			rq.starts[s] = pos_t'($urandom);
			rq.ends[s]   = pos_t'($urandom);
		end
		rq.starts[0] = first_start;
		return rq;
	endfunction

	function automatic list_request_t read_req(int idx);
		list_request_t rq;
		rq            = thread_req(OP_READ, inst_t'($urandom), pos_t'($urandom));
		rq.read_index = eidx_t'(idx);
		return rq;
	endfunction

	// ids come mostly from a pool a bit larger than the list, so the list
	// fills, hits repeat, and new ids then bounce off a full list
	function automatic list_request_t random_request(int pool_base);
		list_request_t rq;
		int            pick;
		pick = $urandom_range(0, 99);
		if (pick < 1) begin
			rq.op = OP_CLEAR;
		end else if (pick < 50) begin
			rq.op = OP_ADD;
		end else if (pick < 70) begin
			rq.op = OP_ADD_EMPTY;
		end else begin
			rq.op = OP_READ;
		end
		if ($urandom_range(0, 99) < 75) begin
			rq.inst = inst_t'(pool_base + $urandom_range(0, POOL_SPAN - 1));
		end else begin
			rq.inst = inst_t'($urandom_range(0, 1023));
		end
		rq.read_index = eidx_t'($urandom_range(0, 31));
		for (int s = 0; s < FIELD_SLOTS; s++) begin
			rq.starts[s] = random_pos();
			rq.ends[s]   = random_pos();
		end
		return rq;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		list_request_t rq;
		cfg_t          phase_cfg[7];
		int            pool_base;

		board        = new();
		hold_request = 1'b0;
		no_idle      = 1'b0;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		req_ch.valid <= 1'b0;
		req_ch.op    <= OP_CLEAR;
		req_ch.inst_id    <= '0;
		req_ch.read_index <= '0;
		req_ch.start_0 <= '0;
		req_ch.end_0   <= '0;
		req_ch.start_1 <= '0;
		req_ch.end_1   <= '0;
		req_ch.start_2 <= '0;
		req_ch.end_2   <= '0;
		req_ch.start_3 <= '0;
		req_ch.end_3   <= '0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part with every slot in use
		write_slots(3'd4);
		offer(read_req(0));                              // read of an empty list
		offer(thread_req(OP_ADD, 10'd5, 16'd100));
		rq        = thread_req(OP_ADD, 10'd0, '1);       // id zero, all ones
		rq.ends   = '1;
		rq.starts = '1;
		offer(rq);
		rq        = thread_req(OP_ADD_EMPTY, 10'd1023, 16'd0);
		rq.ends   = '1;                                  // ends must come back zero
		offer(rq);
		offer(thread_req(OP_ADD, 10'd5, 16'd50));        // smaller start: replace
		offer(thread_req(OP_ADD, 10'd5, 16'd50));        // equal start: keep
		offer(thread_req(OP_ADD, 10'd5, 16'd60));        // larger start: keep
		offer(thread_req(OP_ADD_EMPTY, 10'd5, 16'd10));  // empty thread replaces
		offer(thread_req(OP_ADD, 10'd0, 16'hFFFE));
		offer(thread_req(OP_ADD_EMPTY, 10'd1023, 16'd0));
		for (int i = 0; i < 4; i++) begin
			offer(read_req(i));                          // last one is past the count
		end
		offer(read_req(31));
		offer(thread_req(OP_CLEAR, 10'd5, 16'd0));
		offer(read_req(0));                              // stale entry after clear
		rq        = thread_req(OP_ADD, 10'd0, 16'd0);
		rq.starts = '0;
		rq.ends   = '0;
		offer(rq);
		offer(read_req(0));
		wait_drained();

		// random phases, each under its own slot setting, extremes included
		phase_cfg = '{3'd2, 3'd0, 3'd7, 3'd3, 3'd1, 3'd4, 3'd5};
		foreach (phase_cfg[p]) begin
			write_slots(phase_cfg[p]);
			no_idle   = (p == QUIET_PHASE);
			pool_base = $urandom_range(0, 1023 - POOL_SPAN);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// stall the receiver while the sender keeps pushing
				if (p == HOLD_PHASE && k == 20) begin
					hold_request = 1'b1;
				end
				// pause the sender until the block has answered everything
				if (p == PAUSE_PHASE && k == PHASE_ITEMS / 2) begin
					wait_drained();
				end
				offer(random_request(pool_base));
			end
			wait_drained();
		end
		no_idle = 1'b0;

		if (board.mismatches == 0 && board.pending_results.size() == 0) begin
			$display("[regex_thread_list_insert_core] OK");
		end else begin
			$display("[regex_thread_list_insert_core] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

[regex_thread_list_insert_core.f]
hdl/rxtl_pkg.sv
hdl/rxtl_in_if.sv
hdl/rxtl_out_if.sv
hdl/rxtl_cell.sv
hdl/regex_thread_list_insert_core.sv
tb/regex_thread_list_insert_core_tb.sv
